### sv/tvsl_pkg.sv
// ----------------------------------------------------------------------------
// tvsl_pkg: shared types and constants of the two-axis velocity slew limiter
// Field widths, register indexes, sequencer states and the control and
// status bundles of the iterative root/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tvsl_pkg;

    // field widths
    localparam int CTRL_W     = 16;
    localparam int DT_W       = 16;
    localparam int VEL_W      = 24;
    localparam int MAXV_W     = 23;
    localparam int RATE_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // internal widths
    localparam int MAG_W   = CTRL_W + 1;   // control magnitude, up to 2^15
    localparam int LEN_W   = 32;           // squared length, up to 2^31
    localparam int ROOT_W  = 16;
    localparam int MUL_W   = 24;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int REM_W   = 20;
    localparam int CNT_W   = 5;

    // product scaling
    localparam int TGT_SHIFT = 15;
    localparam int BND_SHIFT = 16;

    // iteration counts of the shared unit
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = MAG_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_RATE   = 2'd2;

    // unit length squared in Q2.30
    localparam logic [LEN_W-1:0] UNIT_LEN2 = 32'h4000_0000;

    // normalized magnitude limits
    localparam logic [MAG_W-1:0] MAG_FULL    = 17'h0_8000;
    localparam logic [MAG_W-1:0] MAG_MAX_POS = 17'h0_7FFF;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_CHECK,
        ST_ROOT,
        ST_DIV_X,
        ST_DIV_Y,
        ST_TARGET,
        ST_DIFF,
        ST_BOUND,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } iter_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage

`default_nettype wire

### sv/tvsl_in_if.sv
// ----------------------------------------------------------------------------
// tvsl_in_if: control input channel
// Valid/ready channel carrying the control vector and the time step.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvsl_in_if;
    import tvsl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CTRL_W-1:0] control_x;
    logic signed [CTRL_W-1:0] control_y;
    logic        [DT_W-1:0]   time_step;

    modport source (output valid, control_x, control_y, time_step, input ready);
    modport sink   (input valid, control_x, control_y, time_step, output ready);
endinterface

`default_nettype wire

### sv/tvsl_out_if.sv
// ----------------------------------------------------------------------------
// tvsl_out_if: velocity output channel
// Valid/ready channel carrying both updated velocities and the scale flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvsl_out_if;
    import tvsl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] velocity_x;
    logic signed [VEL_W-1:0] velocity_y;
    logic                    was_normalized;

    modport source (output valid, velocity_x, velocity_y, was_normalized, input ready);
    modport sink   (input valid, velocity_x, velocity_y, was_normalized, output ready);
endinterface

`default_nettype wire

### sv/two_axis_velocity_slew_limiter_top.sv
// ----------------------------------------------------------------------------
// two_axis_velocity_slew_limiter_top: two-axis velocity slew limiter
// Scales an over-long control vector to unit length, derives a target per
// axis and moves each velocity toward it, bounded by rate * time step.
//
//   channel   | dir | handshake       | payload
//   ----------+-----+-----------------+-------------------------------------
//   control   | in  | valid/ready     | control_x, control_y, time_step
//   velocity  | out | valid/ready     | velocity_x, velocity_y, was_normalized
//   cfg       | in  | cfg_we          | cfg_index, cfg_data
//
// When the vector is scaled, the shared bit-serial subtractor spends 16
// steps on the root and 17 on each divide. Velocity and slew work uses one
// shared 24x24 multiplier, one product per cycle. The next transaction is
// taken after the result is moved to the output register, so a stalled
// output holds at most one finished result. Reset clears both velocities
// and all three registers.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_velocity_slew_limiter_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tvsl_in_if.sink                                control,
    tvsl_out_if.source                             velocity,
    input  wire logic                              cfg_we,
    input  wire logic [tvsl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tvsl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tvsl_pkg::*;

    // control magnitude of a signed Q1.15 value
    function automatic logic [MAG_W-1:0] ctrl_mag(input logic signed [CTRL_W-1:0] v);
        logic signed [MAG_W-1:0] ext;
        ext = MAG_W'(v);
        ctrl_mag = v[CTRL_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
    endfunction

    state_t state_reg, state_next;

    // configuration
    logic [MAXV_W-1:0] max_vel_reg;
    logic [RATE_W-1:0] accel_reg;
    logic [RATE_W-1:0] decel_reg;

    // velocity state
    logic signed [VEL_W-1:0] vel_first_reg, vel_first_next;
    logic signed [VEL_W-1:0] vel_second_reg, vel_second_next;

    // per-transaction working registers
    logic [MAG_W-1:0]  cmag_x_reg, cmag_x_next;
    logic [MAG_W-1:0]  cmag_y_reg, cmag_y_next;
    logic              csgn_x_reg, csgn_x_next;
    logic              csgn_y_reg, csgn_y_next;
    logic [DT_W-1:0]   dt_reg, dt_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic signed [VEL_W:0] d_reg, d_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic              norm_reg, norm_next;
    logic              axis_reg, axis_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [VEL_W-1:0] out_vx_reg, out_vx_next;
    logic signed [VEL_W-1:0] out_vy_reg, out_vy_next;
    logic                    out_norm_reg, out_norm_next;

    // shared multiplier
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_out;

    // iterative unit
    iter_ctrl_t        iter_ctrl;
    iter_stat_t        iter_stat;
    logic [MAG_W-1:0]  iter_result;
    logic [MAG_W-1:0]  iter_numer;
    logic [MAG_W-1:0]  div_clamped;
    logic              div_sgn;

    // per-axis selection and slew arithmetic
    logic [MAG_W-1:0]        cmag_sel;
    logic                    csgn_sel;
    logic signed [VEL_W-1:0] v_sel;
    logic [MAXV_W-1:0]       tmag;
    logic signed [VEL_W-1:0] target;
    logic signed [VEL_W:0]   d_calc;
    logic                    use_decel;
    logic [RATE_W-1:0]       bound;
    logic [VEL_W:0]          dmag;
    logic [VEL_W:0]          move;
    logic signed [VEL_W-1:0] v_new;

    logic in_fire;
    logic out_free;
    logic over_unit;

    assign control.ready = (state_reg == ST_IDLE);
    assign in_fire       = control.valid && (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || velocity.ready;
    assign over_unit     = (len_reg > UNIT_LEN2);

    assign mul_out = mul_a * mul_b;

    tvsl_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (iter_ctrl),
        .radicand (len_reg),
        .numer    (iter_numer),
        .divisor  (root_reg),
        .stat     (iter_stat),
        .result   (iter_result)
    );

    // the divide started from the root state is for x, the next one for y
    assign iter_numer = (state_reg == ST_ROOT) ? cmag_x_reg : cmag_y_reg;
    assign div_sgn    = (state_reg == ST_DIV_X) ? csgn_x_reg : csgn_y_reg;

    // a positive full-scale quotient saturates to the largest Q1.15 value
    assign div_clamped = (!div_sgn && iter_result == MAG_FULL) ? MAG_MAX_POS : iter_result;

    // axis 0 updates the first velocity from y, axis 1 the second from x
    assign cmag_sel = axis_reg ? cmag_x_reg : cmag_y_reg;
    assign csgn_sel = axis_reg ? csgn_x_reg : csgn_y_reg;
    assign v_sel    = axis_reg ? vel_second_reg : vel_first_reg;

    // target and difference
    always_comb
    begin
        tmag   = prod_reg[TGT_SHIFT +: MAXV_W];
        target = csgn_sel ? $signed({1'b0, tmag}) : -$signed({1'b0, tmag});
        d_calc = $signed({target[VEL_W-1], target}) - $signed({v_sel[VEL_W-1], v_sel});
        use_decel = (v_sel != '0) &&
                    !((d_calc != '0) && (d_calc[VEL_W] == v_sel[VEL_W-1]));
    end

    // bounded move
    always_comb
    begin
        bound = prod_reg[BND_SHIFT +: RATE_W];
        dmag  = d_reg[VEL_W] ? (VEL_W+1)'(-d_reg) : (VEL_W+1)'(d_reg);
        move  = (dmag < {1'b0, bound}) ? dmag : {1'b0, bound};
        v_new = d_reg[VEL_W] ? (v_sel - $signed(move[VEL_W-1:0]))
                             : (v_sel + $signed(move[VEL_W-1:0]));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (control.valid) state_next = ST_SQ_X;
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_CHECK;
            ST_CHECK:  state_next = over_unit ? ST_ROOT : ST_TARGET;
            ST_ROOT:   if (iter_stat.done) state_next = ST_DIV_X;
            ST_DIV_X:  if (iter_stat.done) state_next = ST_DIV_Y;
            ST_DIV_Y:  if (iter_stat.done) state_next = ST_TARGET;
            ST_TARGET: state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_BOUND;
            ST_BOUND:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = axis_reg ? ST_FINISH : ST_TARGET;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb
    begin
        cmag_x_next     = cmag_x_reg;
        cmag_y_next     = cmag_y_reg;
        csgn_x_next     = csgn_x_reg;
        csgn_y_next     = csgn_y_reg;
        dt_next         = dt_reg;
        len_next        = len_reg;
        root_next       = root_reg;
        prod_next       = prod_reg;
        d_next          = d_reg;
        rate_next       = rate_reg;
        norm_next       = norm_reg;
        axis_next       = axis_reg;
        vel_first_next  = vel_first_reg;
        vel_second_next = vel_second_reg;
        out_vx_next     = out_vx_reg;
        out_vy_next     = out_vy_reg;
        out_norm_next   = out_norm_reg;
        out_valid_next  = out_valid_reg && !velocity.ready;
        mul_a           = MUL_W'(cmag_sel);
        mul_b           = MUL_W'(max_vel_reg);
        iter_ctrl.start = 1'b0;
        iter_ctrl.op    = OP_SQRT;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmag_x_next = ctrl_mag(control.control_x);
                    cmag_y_next = ctrl_mag(control.control_y);
                    csgn_x_next = control.control_x[CTRL_W-1];
                    csgn_y_next = control.control_y[CTRL_W-1];
                    dt_next     = control.time_step;
                    axis_next   = 1'b0;
                end
            end
            ST_SQ_X:
            begin
                mul_a     = MUL_W'(cmag_x_reg);
                mul_b     = MUL_W'(cmag_x_reg);
                prod_next = mul_out;
            end
            ST_SQ_Y:
            begin
                mul_a     = MUL_W'(cmag_y_reg);
                mul_b     = MUL_W'(cmag_y_reg);
                prod_next = mul_out;
                len_next  = prod_reg[LEN_W-1:0];
            end
            ST_SUM:
            begin
                len_next = len_reg + prod_reg[LEN_W-1:0];
            end
            ST_CHECK:
            begin
                norm_next = over_unit;
                if (over_unit)
                begin
                    iter_ctrl.start = 1'b1;
                    iter_ctrl.op    = OP_SQRT;
                end
            end
            ST_ROOT:
            begin
                if (iter_stat.done)
                begin
                    root_next       = iter_result[ROOT_W-1:0];
                    iter_ctrl.start = 1'b1;
                    iter_ctrl.op    = OP_DIV;
                end
            end
            ST_DIV_X:
            begin
                if (iter_stat.done)
                begin
                    cmag_x_next     = div_clamped;
                    iter_ctrl.start = 1'b1;
                    iter_ctrl.op    = OP_DIV;
                end
            end
            ST_DIV_Y:
            begin
                if (iter_stat.done)
                begin
                    cmag_y_next = div_clamped;
                end
            end
            ST_TARGET:
            begin
                mul_a     = MUL_W'(cmag_sel);
                mul_b     = MUL_W'(max_vel_reg);
                prod_next = mul_out;
            end
            ST_DIFF:
            begin
                d_next    = d_calc;
                rate_next = use_decel ? decel_reg : accel_reg;
            end
            ST_BOUND:
            begin
                mul_a     = MUL_W'(rate_reg);
                mul_b     = MUL_W'(dt_reg);
                prod_next = mul_out;
            end
            ST_UPDATE:
            begin
                if (axis_reg)
                begin
                    vel_second_next = v_new;
                end
                else
                begin
                    vel_first_next = v_new;
                end
                axis_next = 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_vx_next    = vel_first_reg;
                    out_vy_next    = vel_second_reg;
                    out_norm_next  = norm_reg;
                end
            end
            default:
            begin
                axis_next = 1'b0;
            end
        endcase
    end

    // sequencer, velocity state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vel_first_reg  <= '0;
            vel_second_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vel_first_reg  <= vel_first_next;
            vel_second_reg <= vel_second_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vel_reg <= '0;
            accel_reg   <= '0;
            decel_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_VELOCITY: max_vel_reg <= cfg_data[MAXV_W-1:0];
                REG_ACCEL_RATE:   accel_reg   <= cfg_data[RATE_W-1:0];
                REG_DECEL_RATE:   decel_reg   <= cfg_data[RATE_W-1:0];
                default:          ;
            endcase
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        cmag_x_reg   <= cmag_x_next;
        cmag_y_reg   <= cmag_y_next;
        csgn_x_reg   <= csgn_x_next;
        csgn_y_reg   <= csgn_y_next;
        dt_reg       <= dt_next;
        len_reg      <= len_next;
        root_reg     <= root_next;
        prod_reg     <= prod_next;
        d_reg        <= d_next;
        rate_reg     <= rate_next;
        norm_reg     <= norm_next;
        axis_reg     <= axis_next;
        out_vx_reg   <= out_vx_next;
        out_vy_reg   <= out_vy_next;
        out_norm_reg <= out_norm_next;
    end

    assign velocity.valid          = out_valid_reg;
    assign velocity.velocity_x     = out_vx_reg;
    assign velocity.velocity_y     = out_vy_reg;
    assign velocity.was_normalized = out_norm_reg;

endmodule

`default_nettype wire

### sv/tvsl_iter.sv
// ----------------------------------------------------------------------------
// tvsl_iter: bit-serial square root and divide unit
// One subtract/compare per cycle shared by a restoring square root
// (16 steps) and a restoring divide of |c| * 2^15 by the root (17 steps).
// ----------------------------------------------------------------------------
`default_nettype none

module tvsl_iter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tvsl_pkg::iter_ctrl_t          ctrl,
    input  wire logic [tvsl_pkg::LEN_W-1:0]    radicand,
    input  wire logic [tvsl_pkg::MAG_W-1:0]    numer,
    input  wire logic [tvsl_pkg::ROOT_W-1:0]   divisor,
    output tvsl_pkg::iter_stat_t               stat,
    output logic [tvsl_pkg::MAG_W-1:0]         result
);
    import tvsl_pkg::*;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] quot_reg, quot_next;
    logic [LEN_W-1:0] src_reg, src_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    op_t              op_reg, op_next;
    logic             done_reg, done_next;

    logic [REM_W-1:0] sub_a;
    logic [REM_W-1:0] sub_b;
    logic [REM_W:0]   diff;
    logic             fits;

    // shared subtractor: trial root or divisor against the shifted remainder
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            sub_a = {rem_reg[REM_W-3:0], src_reg[LEN_W-1 -: 2]};
            sub_b = {{(REM_W-ROOT_W-2){1'b0}}, quot_reg[ROOT_W-1:0], 2'b01};
        end
        else
        begin
            sub_a = {rem_reg[REM_W-2:0], src_reg[LEN_W-1]};
            sub_b = {{(REM_W-ROOT_W){1'b0}}, divisor};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        fits = ~diff[REM_W];
    end

    // step sequencing
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        src_next  = src_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            op_next   = ctrl.op;
            quot_next = '0;
            if (ctrl.op == OP_SQRT)
            begin
                rem_next = '0;
                src_next = radicand;
                cnt_next = CNT_W'(SQRT_STEPS);
            end
            else
            begin
                rem_next = {{(REM_W-MAG_W+2){1'b0}}, numer[MAG_W-1:2]};
                src_next = {numer[1:0], {(LEN_W-2){1'b0}}};
                cnt_next = CNT_W'(DIV_STEPS);
            end
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[REM_W-1:0] : sub_a;
            quot_next = {quot_reg[MAG_W-2:0], fits};
            src_next  = (op_reg == OP_SQRT) ? {src_reg[LEN_W-3:0], 2'b00}
                                            : {src_reg[LEN_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            op_reg   <= OP_SQRT;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        src_reg  <= src_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign result    = quot_reg;

endmodule

`default_nettype wire
